>>> hw/rtl/lfpa_pkg.sv
package lfpa_pkg;

   // widest per-frame distance sum and point count (up to 32 points per frame)
   localparam int FSUM_W = 21;
   localparam int FCNT_W = 6;

   // queue between the parser and the accumulator
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   // CRC-8, MSB first, no reflection, init 0
   localparam logic [7:0] CRC_POLY = 8'h4D;

   // configuration register indexes
   localparam logic [1:0] CSR_HEADER = 2'd0;
   localparam logic [1:0] CSR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_FRAMES = 2'd2;

   // register reset values
   localparam logic [7:0] HEADER_RST = 8'd84;
   localparam logic [7:0] LENGTH_RST = 8'd44;
   localparam logic [7:0] FRAMES_RST = 8'd10;

   // frame field slots
   localparam logic [1:0] SLOT_TEMP  = 2'd0;
   localparam logic [1:0] SLOT_START = 2'd1;
   localparam logic [1:0] SLOT_END   = 2'd2;
   localparam logic [1:0] SLOT_TIME  = 2'd3;

   // one parsed byte, as handed from the parser to the accumulator
   typedef struct packed {
      logic              ok;
      logic              fend;
      logic              cgood;
      logic              fld_we;
      logic [1:0]        fld_slot;
      logic [15:0]       fld_value;
      logic [FSUM_W-1:0] frm_sum;
      logic [FCNT_W-1:0] frm_cnt;
   } lfpa_op_type;

   // one result transaction
   typedef struct packed {
      logic        ok;
      logic        fend;
      logic        cgood;
      logic        avalid;
      logic [15:0] avg;
      logic        nopts;
      logic [31:0] good;
      logic [15:0] start_ang;
      logic [15:0] end_ang;
      logic [15:0] ftime;
      logic [15:0] temp;
   } lfpa_rsp_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/lfpa_front.sv
module lfpa_front import lfpa_pkg::*; #(
   parameter int POINTS_PER_FRAME = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // rx_byte[7:0]
   input  logic [7:0]  header_value,
   input  logic [7:0]  length_value,
   input  logic        q_full,
   output logic        q_push,
   output lfpa_op_type q_entry
);

   localparam int POINT_START = 6;
   localparam int POINT_END   = POINT_START + 3 * POINTS_PER_FRAME;
   localparam int CRC_POS     = POINT_END + 4;
   localparam int POS_W       = $clog2(CRC_POS + 1);
   localparam int SUM_W       = $clog2(POINTS_PER_FRAME * 65535 + 1);
   localparam int CNT_W       = $clog2(POINTS_PER_FRAME + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       low_ff, low_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       phase_ff, phase_in;

   logic             accept;
   logic [7:0]       b;
   logic [15:0]      word;
   logic [7:0]       crc_next;
   logic             pre_points;
   logic             in_points;
   logic [POS_W-1:0] off;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign q_push     = accept;
   assign b          = req_tdata;
   assign word       = {b, low_ff};
   assign crc_next   = crc8_update(crc_ff, b);
   assign pre_points = pos_ff < POS_W'(POINT_START);
   assign in_points  = !pre_points && (pos_ff < POS_W'(POINT_END));
   assign off        = pre_points ? (pos_ff - POS_W'(2)) : (pos_ff - POS_W'(POINT_END));

   // classify the byte by its place in the frame
   always_comb begin
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      low_in   = low_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      q_entry  = '0;
      q_entry.ok = 1'b1;
      if (pos_ff == '0) begin
         if (b == header_value) begin
            crc_in = crc_next;
            pos_in = POS_W'(1);
         end else begin
            crc_in = '0;
            sum_in = '0;
            cnt_in = '0;
            q_entry.ok = 1'b0;
         end
      end else if (pos_ff == POS_W'(1)) begin
         if (b == length_value) begin
            crc_in = crc_next;
            pos_in = POS_W'(2);
         end else begin
            pos_in = '0;
            crc_in = '0;
            sum_in = '0;
            cnt_in = '0;
            q_entry.ok = 1'b0;
         end
      end else if (pos_ff < POS_W'(CRC_POS)) begin
         crc_in = crc_next;
         pos_in = pos_ff + POS_W'(1);
         if (in_points) begin
            // point: distance low, distance high, intensity
            phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
            if (phase_ff == 2'd0) begin
               low_in = b;
            end else if (phase_ff == 2'd1 && word != 16'd0) begin
               sum_in = sum_ff + SUM_W'(word);
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end else if (off[0]) begin
            q_entry.fld_we    = 1'b1;
            q_entry.fld_slot  = {!pre_points, off[1]};
            q_entry.fld_value = word;
         end else begin
            low_in = b;
         end
      end else begin
         // CRC byte closes the frame
         q_entry.fend    = 1'b1;
         q_entry.cgood   = (b == crc_ff);
         q_entry.ok      = (b == crc_ff);
         q_entry.frm_sum = FSUM_W'(sum_ff);
         q_entry.frm_cnt = FCNT_W'(cnt_ff);
         pos_in   = '0;
         crc_in   = '0;
         sum_in   = '0;
         cnt_in   = '0;
         phase_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         crc_ff   <= '0;
         low_ff   <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= 2'd0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         low_ff   <= low_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
   end

endmodule

>>> hw/rtl/lfpa_queue.sv
module lfpa_queue import lfpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  lfpa_op_type push_data,
   input  logic        pop,
   output lfpa_op_type pop_data,
   output logic        full,
   output logic        empty
);

   lfpa_op_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_in  = push ? wr_ff + Q_PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + Q_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/lfpa_back.sv
module lfpa_back import lfpa_pkg::*; #(
   parameter int POINTS_PER_FRAME = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   frames_per_average,
   input  logic         q_empty,
   input  lfpa_op_type  q_entry,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // byte_ok, crc_good, avg_valid, avg_distance[15:0], no_points, good_frames[31:0],
   // sweep_start[15:0], sweep_stop[15:0], frame_time[15:0], sensor_temp[15:0], 4 zero bits
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast      // frame_end
);

   localparam int SUM_W = $clog2(POINTS_PER_FRAME * 65535 + 1);
   localparam int CNT_W = $clog2(POINTS_PER_FRAME + 1);
   localparam int WS_W  = SUM_W + 8;
   localparam int WC_W  = CNT_W + 8;
   localparam int DC_W  = $clog2(WS_W + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [15:0]     fields_ff [4];
   logic [15:0]     fields_in [4];
   logic [31:0]     good_ff, good_in;
   logic [WS_W-1:0] wsum_ff, wsum_in;
   logic [WC_W-1:0] wcnt_ff, wcnt_in;
   logic [7:0]      wfr_ff, wfr_in;
   logic [15:0]     avg_ff, avg_in;
   logic [WC_W-1:0] rem_ff, rem_in;
   logic [WS_W-1:0] quo_ff, quo_in;
   logic [WC_W-1:0] divr_ff, divr_in;
   logic [DC_W-1:0] dcnt_ff, dcnt_in;
   lfpa_rsp_type    rsp_ff, rsp_in;
   logic            rv_ff, rv_in;

   logic            out_free;
   logic            load;
   logic [WS_W-1:0] nsum;
   logic [WC_W-1:0] ncnt;
   logic [8:0]      nfr;
   logic [8:0]      target;
   logic [WC_W:0]   rem_sh;

   assign out_free = !rv_ff || rsp_tready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty && out_free;
   assign nsum     = wsum_ff + WS_W'(q_entry.frm_sum);
   assign ncnt     = wcnt_ff + WC_W'(q_entry.frm_cnt);
   assign nfr      = {1'b0, wfr_ff} + 9'd1;
   assign target   = (frames_per_average == 8'd0) ? 9'd256 : {1'b0, frames_per_average};
   assign rem_sh   = {rem_ff, quo_ff[WS_W-1]};

   // accumulate, divide and build the result
   always_comb begin
      state_in  = state_ff;
      fields_in = fields_ff;
      good_in   = good_ff;
      wsum_in   = wsum_ff;
      wcnt_in   = wcnt_ff;
      wfr_in    = wfr_ff;
      avg_in    = avg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      divr_in   = divr_ff;
      dcnt_in   = dcnt_ff;
      rsp_in    = rsp_ff;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               rsp_in        = '0;
               rsp_in.ok     = q_entry.ok;
               rsp_in.fend   = q_entry.fend;
               rsp_in.cgood  = q_entry.cgood;
               if (q_entry.fld_we) begin
                  fields_in[q_entry.fld_slot] = q_entry.fld_value;
               end
               load = 1'b1;
               if (q_entry.cgood) begin
                  good_in = good_ff + 32'd1;
                  if (nfr >= target) begin
                     wsum_in = '0;
                     wcnt_in = '0;
                     wfr_in  = '0;
                     if (ncnt == '0) begin
                        avg_in        = '0;
                        rsp_in.avalid = 1'b1;
                        rsp_in.nopts  = 1'b1;
                     end else begin
                        // mean needs the serial divider
                        load     = 1'b0;
                        state_in = ST_DIV;
                        rem_in   = '0;
                        quo_in   = nsum;
                        divr_in  = ncnt;
                        dcnt_in  = '0;
                     end
                  end else begin
                     wsum_in = nsum;
                     wcnt_in = ncnt;
                     wfr_in  = nfr[7:0];
                  end
               end
               rsp_in.avg       = avg_in;
               rsp_in.good      = good_in;
               rsp_in.start_ang = fields_in[SLOT_START];
               rsp_in.end_ang   = fields_in[SLOT_END];
               rsp_in.ftime     = fields_in[SLOT_TIME];
               rsp_in.temp      = fields_in[SLOT_TEMP];
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, divr_ff}) begin
               rem_in = WC_W'(rem_sh - {1'b0, divr_ff});
               quo_in = {quo_ff[WS_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[WC_W-1:0];
               quo_in = {quo_ff[WS_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(WS_W - 1)) begin
               avg_in   = quo_in[15:0];
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_in.ok        = 1'b1;
               rsp_in.fend      = 1'b1;
               rsp_in.cgood     = 1'b1;
               rsp_in.avalid    = 1'b1;
               rsp_in.nopts     = 1'b0;
               rsp_in.avg       = avg_ff;
               rsp_in.good      = good_ff;
               rsp_in.start_ang = fields_ff[SLOT_START];
               rsp_in.end_ang   = fields_ff[SLOT_END];
               rsp_in.ftime     = fields_ff[SLOT_TIME];
               rsp_in.temp      = fields_ff[SLOT_TEMP];
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (load) begin
         rv_in = 1'b1;
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end else begin
         rv_in = rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fields_ff <= '{default: '0};
         good_ff   <= '0;
         wsum_ff   <= '0;
         wcnt_ff   <= '0;
         wfr_ff    <= '0;
         avg_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fields_ff <= fields_in;
         good_ff   <= good_in;
         wsum_ff   <= wsum_in;
         wcnt_ff   <= wcnt_in;
         wfr_ff    <= wfr_in;
         avg_ff    <= avg_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      divr_ff <= divr_in;
      dcnt_ff <= dcnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rsp_ff.fend;
   assign rsp_tdata  = {4'd0, rsp_ff.temp, rsp_ff.ftime, rsp_ff.end_ang, rsp_ff.start_ang,
                        rsp_ff.good, rsp_ff.nopts, rsp_ff.avg, rsp_ff.avalid,
                        rsp_ff.cgood, rsp_ff.ok};

endmodule

>>> hw/rtl/lidar_frame_parser_averager_unit.sv
// Range-sensor frame parser with windowed distance averaging.
// req_ channel: one received sensor byte per transaction (req_tdata[7:0]).
// rsp_ channel: exactly one result transaction per accepted byte, in order:
//   status flags, the latest average, the good-frame count and the latest
//   frame fields; rsp_tlast marks the CRC byte of a frame.
// csr_ port: header value (0), length value (1), frames per average (2);
//   written only while idle, a rule on the user that the block does not enforce.
// Each ordinary byte passes through the queue and then the output register on its way to
//   a result; one byte per cycle sustained while the result side keeps up and the divider is idle.
// The CRC byte that closes an averaging window with counted points runs the serial restoring
//   divider, one quotient bit per cycle over the window sum width
//   (28 bits at 12 points per frame).
// A four-entry queue sits between the parser and the accumulator; when the
//   result side stalls or the divider runs, the queue fills and then
//   req_tready drops. A finished result waits in the output register.
// Reset is synchronous: parser, window, counters and frame fields clear and
//   the registers return to header 0x54, length 0x2C and ten frames.
module lidar_frame_parser_averager_unit import lfpa_pkg::*; #(
   parameter int POINTS_PER_FRAME = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // rx_byte[7:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // byte_ok, crc_good, avg_valid, avg_distance[15:0], no_points, good_frames[31:0],
   // sweep_start[15:0], sweep_stop[15:0], frame_time[15:0], sensor_temp[15:0], 4 zero bits
   output logic [119:0] rsp_tdata,
   output logic         rsp_tlast,     // frame_end
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [7:0]   csr_wdata
);

   logic [7:0]  hdr_ff, hdr_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  fpa_ff, fpa_in;

   logic        q_full;
   logic        q_empty;
   logic        q_push;
   logic        q_pop;
   lfpa_op_type q_wdata;
   lfpa_op_type q_rdata;

   // configuration registers
   always_comb begin
      hdr_in = hdr_ff;
      len_in = len_ff;
      fpa_in = fpa_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_HEADER: hdr_in = csr_wdata;
            CSR_LENGTH: len_in = csr_wdata;
            CSR_FRAMES: fpa_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= HEADER_RST;
         len_ff <= LENGTH_RST;
         fpa_ff <= FRAMES_RST;
      end else begin
         hdr_ff <= hdr_in;
         len_ff <= len_in;
         fpa_ff <= fpa_in;
      end
   end

   lfpa_front #(
      .POINTS_PER_FRAME(POINTS_PER_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .header_value (hdr_ff),
      .length_value (len_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_wdata)
   );

   lfpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   lfpa_back #(
      .POINTS_PER_FRAME(POINTS_PER_FRAME)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .frames_per_average (fpa_ff),
      .q_empty            (q_empty),
      .q_entry            (q_rdata),
      .q_pop              (q_pop),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast)
   );

endmodule

>>> tb/tb_lidar_frame_parser_averager_unit.sv
`timescale 1ns / 100ps

module tb_lidar_frame_parser_averager_unit;
   import lfpa_pkg::*;

   localparam int PTS       = 12;
   localparam int PT_FIRST  = 6;
   localparam int PT_LAST   = PT_FIRST + 3 * PTS;
   localparam int CRC_AT    = PT_LAST + 4;
   localparam int DRAIN     = 40;     // covers the serial divider on a window close
   localparam int PHASE_LEN = 80;     // bytes per random phase, at least

   // directed row: byte, pinned expectation flag, pinned byte_ok, pinned sensor_temp
   typedef struct packed {
      logic [7:0]  b;
      logic        pinned;
      logic        ok;
      logic [15:0] temp;
   } dir_row_type;

   typedef enum int {
      FR_GOOD, FR_ZERO, FR_MAX, FR_BADCRC, FR_NOISE, FR_BADLEN, FR_CUT
   } frame_kind_type;

   // after reset: 0x54 header, 0x2C length, all state zero
   localparam dir_row_type [0:19] DIR_ROWS = {
      {8'h00, 1'b1, 1'b0, 16'h0000},   // header mismatch
      {8'hFF, 1'b1, 1'b0, 16'h0000},   // header mismatch
      {8'h2C, 1'b1, 1'b0, 16'h0000},   // length value in the header place, mismatch
      {8'h54, 1'b1, 1'b1, 16'h0000},   // header
      {8'h54, 1'b1, 1'b0, 16'h0000},   // length mismatch, not re-taken as header
      {8'h54, 1'b1, 1'b1, 16'h0000},   // header
      {8'h2C, 1'b1, 1'b1, 16'h0000},   // length
      {8'hFF, 1'b1, 1'b1, 16'h0000},   // temp low
      {8'hFF, 1'b1, 1'b1, 16'hFFFF},   // temp high
      {8'h00, 1'b0, 1'b0, 16'h0000},   // start angle low
      {8'h80, 1'b0, 1'b0, 16'h0000},   // start angle high
      {8'hFF, 1'b0, 1'b0, 16'h0000},   // largest distance
      {8'hFF, 1'b0, 1'b0, 16'h0000},
      {8'h7E, 1'b0, 1'b0, 16'h0000},   // intensity
      {8'h00, 1'b0, 1'b0, 16'h0000},   // zero distance, not counted
      {8'h00, 1'b0, 1'b0, 16'h0000},
      {8'h01, 1'b0, 1'b0, 16'h0000},
      {8'h01, 1'b0, 1'b0, 16'h0000},   // distance of one
      {8'h00, 1'b0, 1'b0, 16'h0000},
      {8'h00, 1'b0, 1'b0, 16'h0000}
   };

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_addr   = 2'd0;
   logic [7:0]   csr_wdata  = 8'h00;

   // predictor copy of the registers
   logic [7:0]  cfg_header = HEADER_RST;
   logic [7:0]  cfg_length = LENGTH_RST;
   logic [7:0]  cfg_frames = FRAMES_RST;

   // predictor copy of the parser and window state
   int unsigned      pos;
   logic [7:0]       crc_run;
   logic [7:0]       low_hold;
   int unsigned      frm_sum;
   int unsigned      frm_cnt;
   longint unsigned  win_sum;
   int unsigned      win_cnt;
   int unsigned      win_frames;
   logic [15:0]      avg_hold;
   logic [31:0]      good_total;
   logic [15:0]      fld [4];

   lfpa_rsp_type     pending_results [$];
   logic [7:0]       frame_bytes [$];
   lfpa_rsp_type     seen_rsp, due_rsp;

   int errors, bytes_sent, results_seen, averages_seen, empty_windows, crc_fails;
   int burst_left, rdy_cycle;
   bit steady;

   lidar_frame_parser_averager_unit #(.POINTS_PER_FRAME(PTS)) uut (.*);

   always #5 clock = ~clock;

   // CRC-8, poly 0x4D, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      repeat (8) c = c[7] ? ((c << 1) ^ 8'h4D) : (c << 1);
      return c;
   endfunction

   function automatic void restart_parse();
      pos = 0;
      crc_run = 8'h00;
      frm_sum = 0;
      frm_cnt = 0;
   endfunction

   // expected result of one byte; advances the predictor state
   function automatic lfpa_rsp_type parse_and_average(input logic [7:0] b);
      lfpa_rsp_type r;
      int unsigned slot, hi, target;
      logic [15:0] d;
      r = '0;
      r.ok = 1'b1;
      if (pos == 0) begin
         if (b == cfg_header) begin
            crc_run = crc8_step(crc_run, b);
            pos = 1;
         end else begin
            restart_parse();
            r.ok = 1'b0;
         end
      end else if (pos == 1) begin
         if (b == cfg_length) begin
            crc_run = crc8_step(crc_run, b);
            pos = 2;
         end else begin
            restart_parse();
            r.ok = 1'b0;
         end
      end else if (pos < CRC_AT) begin
         crc_run = crc8_step(crc_run, b);
         if (pos >= PT_FIRST && pos < PT_LAST) begin
            // distance low, distance high, intensity (CRC only)
            case ((pos - PT_FIRST) % 3)
               0: low_hold = b;
               1: begin
                  d = {b, low_hold};
                  if (d != 16'h0000) begin
                     frm_sum += d;
                     frm_cnt++;
                  end
               end
               default: ;
            endcase
         end else begin
            if (pos < PT_FIRST) begin
               slot = (pos - 2) >> 1;
               hi   = (pos - 2) & 1;
            end else begin
               slot = 2 + ((pos - PT_LAST) >> 1);
               hi   = (pos - PT_LAST) & 1;
            end
            if (hi != 0) fld[slot] = {b, low_hold};
            else low_hold = b;
         end
         pos++;
      end else begin
         r.fend = 1'b1;
         if (b == crc_run) begin
            r.cgood = 1'b1;
            good_total++;
            win_sum += frm_sum;
            win_cnt += frm_cnt;
            win_frames++;
            target = (cfg_frames == 8'd0) ? 256 : cfg_frames;
            if (win_frames >= target) begin
               r.avalid = 1'b1;
               if (win_cnt == 0) begin
                  avg_hold = 16'h0000;
                  r.nopts  = 1'b1;
               end else begin
                  avg_hold = 16'(win_sum / win_cnt);
               end
               win_sum    = 0;
               win_cnt    = 0;
               win_frames = 0;
            end
         end else begin
            r.ok = 1'b0;
         end
         restart_parse();
      end
      r.avg       = avg_hold;
      r.good      = good_total;
      r.start_ang = fld[SLOT_START];
      r.end_ang   = fld[SLOT_END];
      r.ftime     = fld[SLOT_TIME];
      r.temp      = fld[SLOT_TEMP];
      return r;
   endfunction

   // one byte in bursts with random gaps; pinned rows carry a typed expectation
   task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                            input lfpa_rsp_type pinned_rsp = '0);
      lfpa_rsp_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = parse_and_average(b);
      pending_results.push_back(pinned ? pinned_rsp : r);
      bytes_sent++;
   endtask

   // wait until every result is back and the divider has had time to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // writes all three registers on consecutive cycles
   task automatic set_config(input logic [7:0] hdr, input logic [7:0] len,
                             input logic [7:0] frames);
      settle();
      csr_we <= 1'b1; csr_addr <= CSR_HEADER; csr_wdata <= hdr;
      @(posedge clock);
      csr_addr <= CSR_LENGTH; csr_wdata <= len;
      @(posedge clock);
      csr_addr <= CSR_FRAMES; csr_wdata <= frames;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_header = hdr;
      cfg_length = len;
      cfg_frames = frames;
   endtask

   function automatic logic [15:0] rand_word(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 16'h0000;
      if (r < zero_pct + 10) return 16'hFFFF;
      if (r < zero_pct + 30) return 16'($urandom_range(1, 255));
      return 16'($urandom);
   endfunction

   function automatic void push_word(input logic [15:0] w);
      frame_bytes.push_back(w[7:0]);
      frame_bytes.push_back(w[15:8]);
   endfunction

   // builds one frame for the current header/length, then spoils it per kind
   task automatic run_frame(input frame_kind_type kind);
      logic [7:0]  crc;
      logic [15:0] d;
      int cut;
      frame_bytes.delete();
      frame_bytes.push_back(cfg_header);
      frame_bytes.push_back(kind == FR_BADLEN ? cfg_length ^ 8'($urandom_range(1, 255))
                                              : cfg_length);
      push_word(rand_word(15));
      push_word(rand_word(15));
      for (int p = 0; p < PTS; p++) begin
         d = (kind == FR_ZERO) ? 16'h0000 : (kind == FR_MAX) ? 16'hFFFF : rand_word(25);
         push_word(d);
         frame_bytes.push_back(8'($urandom));
      end
      push_word(rand_word(15));
      push_word(rand_word(15));
      crc = 8'h00;
      foreach (frame_bytes[i]) crc = crc8_step(crc, frame_bytes[i]);
      frame_bytes.push_back(kind == FR_BADCRC ? crc ^ 8'($urandom_range(1, 255)) : crc);
      if (kind == FR_CUT) begin
         cut = $urandom_range(3, CRC_AT - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end else if (kind == FR_NOISE) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   function automatic frame_kind_type pick_kind(input bit mostly_good);
      int r;
      r = $urandom_range(0, 99);
      if (mostly_good) return (r < 95) ? FR_GOOD : FR_BADCRC;
      if (r < 62) return FR_GOOD;
      if (r < 66) return FR_ZERO;
      if (r < 68) return FR_MAX;
      if (r < 78) return FR_BADCRC;
      if (r < 86) return FR_NOISE;
      if (r < 93) return FR_BADLEN;
      return FR_CUT;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   // result side: own stall pattern, and compare each transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rdy_cycle++;
         case ((rdy_cycle >> 9) % 3)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ((rdy_cycle & 15) < 5);
         endcase
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.ok        = rsp_tdata[0];
            seen_rsp.fend      = rsp_tlast;
            seen_rsp.cgood     = rsp_tdata[1];
            seen_rsp.avalid    = rsp_tdata[2];
            seen_rsp.avg       = rsp_tdata[18:3];
            seen_rsp.nopts     = rsp_tdata[19];
            seen_rsp.good      = rsp_tdata[51:20];
            seen_rsp.start_ang = rsp_tdata[67:52];
            seen_rsp.end_ang   = rsp_tdata[83:68];
            seen_rsp.ftime     = rsp_tdata[99:84];
            seen_rsp.temp      = rsp_tdata[115:100];
            results_seen++;
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: result with none expected, got %h", $time, rsp_tdata);
            end else begin
               due_rsp = pending_results.pop_front();
               if (due_rsp.avalid) averages_seen++;
               if (due_rsp.nopts) empty_windows++;
               if (due_rsp.fend && !due_rsp.cgood) crc_fails++;
               check_field("byte_ok", due_rsp.ok, seen_rsp.ok);
               check_field("frame_end", due_rsp.fend, seen_rsp.fend);
               check_field("crc_good", due_rsp.cgood, seen_rsp.cgood);
               check_field("avg_valid", due_rsp.avalid, seen_rsp.avalid);
               check_field("avg_distance", due_rsp.avg, seen_rsp.avg);
               check_field("no_points", due_rsp.nopts, seen_rsp.nopts);
               check_field("good_frames", due_rsp.good, seen_rsp.good);
               check_field("sweep_start", due_rsp.start_ang, seen_rsp.start_ang);
               check_field("sweep_stop", due_rsp.end_ang, seen_rsp.end_ang);
               check_field("frame_time", due_rsp.ftime, seen_rsp.ftime);
               check_field("sensor_temp", due_rsp.temp, seen_rsp.temp);
            end
         end
      end
   end

   // stimulus
   initial begin
      lfpa_rsp_type pin;
      int sent_mark;
      restart_parse();
      low_hold   = 8'h00;
      win_sum    = 0;
      win_cnt    = 0;
      win_frames = 0;
      avg_hold   = 16'h0000;
      good_total = 32'h0;
      foreach (fld[i]) fld[i] = 16'h0000;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset values
      foreach (DIR_ROWS[i]) begin
         pin = '0;
         pin.ok   = DIR_ROWS[i].ok;
         pin.temp = DIR_ROWS[i].temp;
         send_byte(DIR_ROWS[i].b, DIR_ROWS[i].pinned, pin);
      end
      // finish the open frame with random bytes; its CRC byte will almost surely fail
      while (pos != 0) send_byte(8'($urandom));

      // single-frame windows: empty window, largest distances, bad CRC, ordinary
      set_config(HEADER_RST, LENGTH_RST, 8'd1);
      run_frame(FR_ZERO);
      run_frame(FR_MAX);
      run_frame(FR_BADCRC);
      run_frame(FR_GOOD);

      // random phases over a range of register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0:       set_config(8'h00, 8'hFF, 8'd1);
            1:       set_config(8'hFF, 8'h00, 8'd3);
            2:       set_config(8'($urandom), 8'($urandom), 8'd255);
            3:       set_config(HEADER_RST, LENGTH_RST, 8'd0);
            4:       set_config(8'($urandom), 8'($urandom), 8'd8);
            5:       set_config(8'($urandom), 8'($urandom), 8'd1);
            default: set_config(8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)));
         endcase
         steady = (ph % 4 == 1);
         sent_mark = bytes_sent;
         // zero register means a 256-frame window, which stays open here
         while (bytes_sent - sent_mark < PHASE_LEN) run_frame(pick_kind(ph == 3));
      end

      settle();
      $display("Covered %0d bytes and %0d results: %0d good frames, %0d CRC failures,",
               bytes_sent, results_seen, good_total, crc_fails);
      $display("%0d averages (%0d empty windows), frames-per-average settings 0 to 255.",
               averages_seen, empty_windows);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard
   initial begin
      #25_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/lfpa_pkg.sv
hw/rtl/lfpa_front.sv
hw/rtl/lfpa_queue.sv
hw/rtl/lfpa_back.sv
hw/rtl/lidar_frame_parser_averager_unit.sv
tb/tb_lidar_frame_parser_averager_unit.sv
